[rtl/core/gfu_pkg.sv]
// ============================================================================
// gfu_pkg: shared types and constants of the gshare fetch unit
// Field widths, codes, latch layouts and the 2-bit counter update.
// ============================================================================
package gfu_pkg;

  localparam int PC_W        = 22;
  localparam int INSTR_W     = 32;
  localparam int HIST_W      = 16;
  localparam int OP_W        = 6;
  localparam int CNT_W       = 2;
  localparam int PHT_AW      = 16;
  localparam int PHT_DEPTH   = 65536;
  localparam int LOAD_ADDR_W = 15;
  localparam int JUMP_TGT_W  = 18;
  localparam int BR_TGT_W    = 15;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 104;

  localparam logic [PC_W-1:0]  PC_RESET    = 22'd3;
  localparam logic [CNT_W-1:0] CNT_WEAK_NT = 2'd1;
  localparam logic [CNT_W-1:0] CNT_WEAK_T  = 2'd2;
  localparam logic [CNT_W-1:0] CNT_MAX     = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MIN     = 2'd0;

  // Item kinds carried in tuser.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_OP     = 1'b1;

  typedef struct packed {
    logic [HIST_W-1:0]  index;
    logic [INSTR_W-1:0] pred;
    logic [INSTR_W-1:0] instr;
    logic [PC_W-1:0]    pc;
  } first_latch_t;

  typedef struct packed {
    logic               miss;
    logic [HIST_W-1:0]  index;
    logic [INSTR_W-1:0] pred;
    logic [INSTR_W-1:0] instr;
    logic [PC_W-1:0]    pc;
  } second_latch_t;

  // Saturating 2-bit counter step toward the actual outcome.
  function automatic logic [CNT_W-1:0] cnt_train(input logic [CNT_W-1:0] cnt,
                                                 input logic taken);
    logic [CNT_W-1:0] res;
    res = cnt;
    if (taken) begin
      if (cnt != CNT_MAX) res = cnt + 1'b1;
    end else begin
      if (cnt != CNT_MIN) res = cnt - 1'b1;
    end
    return res;
  endfunction

endpackage

[rtl/core/gfu_rom.sv]
// ============================================================================
// gfu_rom: instruction memory
// Single-port write, registered read, with same-edge write forwarding.
// ============================================================================
module gfu_rom #(
  parameter int DEPTH = 32768
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [gfu_pkg::INSTR_W-1:0]      wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [gfu_pkg::INSTR_W-1:0]      rdata
);

  logic [gfu_pkg::INSTR_W-1:0] mem [DEPTH];
  logic [gfu_pkg::INSTR_W-1:0] mem_q;
  logic [gfu_pkg::INSTR_W-1:0] fwd_data;
  logic                        fwd;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      mem_q    <= mem[raddr];
      fwd_data <= wdata;
    end
  end

  // A write landing on the address read at the same edge wins over the old word.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (re) begin
      fwd <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd ? fwd_data : mem_q;

endmodule

[rtl/core/gfu_pht.sv]
// ============================================================================
// gfu_pht: pattern history table
// 2-bit counters in a synchronous memory, cleared to weakly not taken by a
// sweep after reset, with same-edge write forwarding.
// ============================================================================
module gfu_pht (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          busy,
  input  logic                          we,
  input  logic [gfu_pkg::PHT_AW-1:0]    waddr,
  input  logic [gfu_pkg::CNT_W-1:0]     wdata,
  input  logic                          re,
  input  logic [gfu_pkg::PHT_AW-1:0]    raddr,
  output logic [gfu_pkg::CNT_W-1:0]     rdata
);

  logic [gfu_pkg::CNT_W-1:0]  mem [gfu_pkg::PHT_DEPTH];
  logic [gfu_pkg::CNT_W-1:0]  mem_q;
  logic [gfu_pkg::CNT_W-1:0]  fwd_data;
  logic                       fwd;
  logic [gfu_pkg::PHT_AW-1:0] clr_addr;
  logic                       wr_en;
  logic [gfu_pkg::PHT_AW-1:0] wr_addr;
  logic [gfu_pkg::CNT_W-1:0]  wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {gfu_pkg::PHT_AW{1'b1}}) busy <= 1'b0;
    end
  end

  always_comb begin
    wr_en   = busy | we;
    wr_addr = busy ? clr_addr : waddr;
    wr_data = busy ? gfu_pkg::CNT_WEAK_NT : wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (re) begin
      mem_q    <= mem[raddr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (re) begin
      fwd <= wr_en && (wr_addr == raddr);
    end
  end

  assign rdata = fwd ? fwd_data : mem_q;

endmodule

[rtl/core/gshare_fetch_unit_core.sv]
// ============================================================================
// gshare_fetch_unit_core: fetch stage with a gshare branch predictor
// Loads an instruction memory word by word and runs fetch steps that apply
// branch commits, train the counters on a mispredict, follow jumps and
// predict branches, emitting the second fetch latch for every step.
// ============================================================================
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: kind; tdata: load and fetch-step fields
// m_axis    out        tdata: second latch (pc, instr, pred, index, miss)
// cfg       in         cfg_we / cfg_index / cfg_data register write
//
// One beat is accepted per clock unless the table sweep runs or a fetch step
// waits on a full output. A beat enters the execute register at the edge it
// is accepted, and the instruction word and counter it needs are read from
// the two memories at that same edge. Addresses for the next beat come from
// the next-PC and next-history logic of the beat in execute, closing the
// fetch loop. After reset the counter table is swept to weakly not taken,
// one entry per clock, with s_axis_tready low until it ends; config writes
// are taken. A full, untaken output beat stalls only fetch steps; loads retire.
//
module gshare_fetch_unit_core #(
  parameter int ROM_DEPTH = 32768
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // from bit 0: load_addr(15) load_word(32) halt(1) commit_branch(1)
  //             commit_data(32) commit_index(16), zero pad(7)
  input  logic [gfu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // bit 0: kind
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // from bit 0: out_pc(22) out_instr(32) out_pred_word(32) out_pred_index(16)
  //             out_mispredict(1), zero pad(1)
  output logic [gfu_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [gfu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ROM_AW = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
  localparam bit ROM_POW2 = ((ROM_DEPTH & (ROM_DEPTH - 1)) == 0);
  // Reciprocal for reducing a PC modulo a depth that is not a power of two.
  localparam int RED_S = gfu_pkg::PC_W + ROM_AW;
  localparam logic [63:0] RECIP   = (64'd1 << RED_S) / ROM_DEPTH;
  localparam logic [63:0] DEPTH64 = 64'(ROM_DEPTH);

  // The reciprocal estimate is at most one below the true quotient, so one
  // conditional subtract finishes the remainder.
  function automatic logic [ROM_AW-1:0] rom_index(input logic [gfu_pkg::PC_W-1:0] x);
    logic [63:0] prod;
    logic [63:0] quo;
    logic [63:0] rem;
    prod = 64'(x) * RECIP;
    quo  = prod >> RED_S;
    rem  = 64'(x) - quo * DEPTH64;
    if (rem >= DEPTH64) rem = rem - DEPTH64;
    if (ROM_POW2) rem = 64'(x);
    return rem[ROM_AW-1:0];
  endfunction

  // Input beat fields.
  logic                                in_kind;
  logic [gfu_pkg::LOAD_ADDR_W-1:0]     in_load_addr;
  logic [gfu_pkg::INSTR_W-1:0]         in_load_word;
  logic                                in_halt;
  logic                                in_commit;
  logic [gfu_pkg::INSTR_W-1:0]         in_cdata;
  logic [gfu_pkg::HIST_W-1:0]          in_cidx;

  assign in_kind      = s_axis_tuser[0];
  assign in_load_addr = s_axis_tdata[14:0];
  assign in_load_word = s_axis_tdata[46:15];
  assign in_halt      = s_axis_tdata[47];
  assign in_commit    = s_axis_tdata[48];
  assign in_cdata     = s_axis_tdata[80:49];
  assign in_cidx      = s_axis_tdata[96:81];

  // Configuration.
  logic [63:0]                 branch_mask;
  logic [gfu_pkg::OP_W-1:0]    jump_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      branch_mask <= '0;
      jump_op     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gfu_pkg::CFG_BRANCH_MASK: branch_mask <= cfg_data;
        gfu_pkg::CFG_JUMP_OP:     jump_op     <= cfg_data[gfu_pkg::OP_W-1:0];
        default: ;
      endcase
    end
  end

  // Execute register: the beat whose memory words are being read out.
  logic                                ex_valid;
  logic                                ex_kind;
  logic [gfu_pkg::LOAD_ADDR_W-1:0]     ex_load_addr;
  logic [gfu_pkg::INSTR_W-1:0]         ex_load_word;
  logic                                ex_halt;
  logic                                ex_commit;
  logic [gfu_pkg::INSTR_W-1:0]         ex_cdata;
  logic [gfu_pkg::HIST_W-1:0]          ex_cidx;

  // Architectural state.
  logic [gfu_pkg::PC_W-1:0]            fetch_pc, fetch_pc_next;
  logic [gfu_pkg::HIST_W-1:0]          history, history_next;
  gfu_pkg::first_latch_t               fl, fl_next;
  gfu_pkg::second_latch_t              sl, sl_next;
  logic                                out_valid;

  // Handshake and retire conditions.
  logic                                pht_busy;
  logic                                in_fire;
  logic                                ex_fire;
  logic                                ex_fetch_fire;

  // A fetch step needs the output slot; a load never does.
  assign ex_fire       = ex_valid &&
                         (ex_kind == gfu_pkg::KIND_LOAD || !out_valid || m_axis_tready);
  assign ex_fetch_fire = ex_fire && (ex_kind == gfu_pkg::KIND_FETCH);
  assign s_axis_tready = !pht_busy && (!ex_valid || ex_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Memory read data for the beat in execute.
  logic [gfu_pkg::INSTR_W-1:0]         code;
  logic [gfu_pkg::CNT_W-1:0]           cnt;

  // Execute logic.
  logic                                ex_actual;
  logic                                ex_miss;
  logic [gfu_pkg::OP_W-1:0]            op;
  logic                                is_jump;
  logic                                is_branch;
  logic [gfu_pkg::HIST_W-1:0]          pred_idx;
  logic [gfu_pkg::PC_W-1:0]            pc_inc;

  assign ex_actual = ex_cdata[30];
  assign ex_miss   = ex_commit && (ex_cdata[30] ^ ex_cdata[31]);
  assign op        = code[gfu_pkg::INSTR_W-1 -: gfu_pkg::OP_W];
  assign is_jump   = (op == jump_op);
  assign is_branch = branch_mask[op];
  assign pc_inc    = fetch_pc + 1'b1;

  always_comb begin
    history_next  = ex_commit ? {history[gfu_pkg::HIST_W-2:0], ex_actual} : history;
    pred_idx      = fetch_pc[gfu_pkg::HIST_W-1:0] ^ history_next;
    fetch_pc_next = fetch_pc;
    fl_next       = fl;
    sl_next       = sl;
    sl_next.miss  = 1'b0;
    if (ex_miss) begin
      // Redirect from the commit and flush the PC and word of both latches.
      sl_next.miss  = 1'b1;
      fetch_pc_next = ex_cdata[gfu_pkg::PC_W-1:0];
      fl_next.pc    = '0;
      fl_next.instr = '0;
      sl_next.pc    = '0;
      sl_next.instr = '0;
    end else if (!ex_halt) begin
      sl_next       = {1'b0, fl};
      fl_next.pc    = fetch_pc;
      fl_next.instr = code;
      if (is_jump) begin
        // The jump wins over a branch with the same opcode and keeps the
        // prediction word and index of the previous fetch.
        fetch_pc_next = {{(gfu_pkg::PC_W-gfu_pkg::JUMP_TGT_W){1'b0}},
                         code[gfu_pkg::JUMP_TGT_W-1:0]};
      end else if (is_branch) begin
        fl_next.index = pred_idx;
        if (cnt >= gfu_pkg::CNT_WEAK_T) begin
          fl_next.pred  = {1'b1, {(gfu_pkg::INSTR_W-1-gfu_pkg::PC_W){1'b0}}, pc_inc};
          fetch_pc_next = {{(gfu_pkg::PC_W-gfu_pkg::BR_TGT_W){1'b0}},
                           code[gfu_pkg::BR_TGT_W-1:0]};
        end else begin
          fl_next.pred  = {{(gfu_pkg::INSTR_W-gfu_pkg::BR_TGT_W){1'b0}},
                           code[gfu_pkg::BR_TGT_W-1:0]};
          fetch_pc_next = pc_inc;
        end
      end else begin
        fl_next.pred  = '0;
        fetch_pc_next = pc_inc;
      end
    end
  end

  // State as it stands after this edge, used to address the next beat's reads.
  logic [gfu_pkg::PC_W-1:0]            pc_now;
  logic [gfu_pkg::HIST_W-1:0]          hist_now;
  logic [gfu_pkg::HIST_W-1:0]          in_hist;
  logic                                in_miss;
  logic [gfu_pkg::PHT_AW-1:0]          pht_raddr;
  logic [ROM_AW-1:0]                   rom_raddr;
  logic [ROM_AW-1:0]                   rom_waddr;

  always_comb begin
    pc_now    = ex_fetch_fire ? fetch_pc_next : fetch_pc;
    hist_now  = ex_fetch_fire ? history_next  : history;
    in_miss   = in_commit && (in_cdata[30] ^ in_cdata[31]);
    in_hist   = in_commit ? {hist_now[gfu_pkg::HIST_W-2:0], in_cdata[30]} : hist_now;
    // A mispredicting beat reads the counter it trains, any other the one it
    // predicts with.
    pht_raddr = in_miss ? in_cidx : (pc_now[gfu_pkg::HIST_W-1:0] ^ in_hist);
    rom_raddr = rom_index(pc_now);
    rom_waddr = rom_index({{(gfu_pkg::PC_W-gfu_pkg::LOAD_ADDR_W){1'b0}}, ex_load_addr});
  end

  gfu_rom #(
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk   (clk),
    .rst   (rst),
    .we    (ex_fire && (ex_kind == gfu_pkg::KIND_LOAD)),
    .waddr (rom_waddr),
    .wdata (ex_load_word),
    .re    (in_fire),
    .raddr (rom_raddr),
    .rdata (code)
  );

  gfu_pht u_pht (
    .clk   (clk),
    .rst   (rst),
    .busy  (pht_busy),
    .we    (ex_fetch_fire && ex_miss),
    .waddr (ex_cidx),
    .wdata (gfu_pkg::cnt_train(cnt, ex_actual)),
    .re    (in_fire),
    .raddr (pht_raddr),
    .rdata (cnt)
  );

  // Execute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_fire) begin
      ex_valid <= 1'b1;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_kind      <= in_kind;
      ex_load_addr <= in_load_addr;
      ex_load_word <= in_load_word;
      ex_halt      <= in_halt;
      ex_commit    <= in_commit;
      ex_cdata     <= in_cdata;
      ex_cidx      <= in_cidx;
    end
  end

  // Fetch state and latches. The second latch is the output register itself:
  // it changes only when a fetch step retires, which needs a free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_pc  <= gfu_pkg::PC_RESET;
      history   <= '0;
      fl        <= '0;
      sl        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ex_fetch_fire) begin
        fetch_pc  <= fetch_pc_next;
        history   <= history_next;
        fl        <= fl_next;
        sl        <= sl_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, sl};

endmodule

[rtl/core/gfu_checker.sv]
// ============================================================================
// gfu_checker: port-level checks of the gshare fetch unit
// Watches the top-level ports only; attached by the bind at the end.
// ============================================================================
module gfu_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [gfu_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  // Reset empties the output and starts the table sweep, so no beat is taken.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!s_axis_tready && !m_axis_tvalid))
    else $error("input ready or output valid right after reset");

  // A flushed beat carries no PC and no instruction word.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[102]) |-> (m_axis_tdata[53:0] == 54'd0))
    else $error("mispredict beat with nonzero pc or instruction");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

endmodule

bind gshare_fetch_unit_core gfu_checker u_gfu_checker (.*);

[bench/gshare_fetch_unit_core_test.sv]
// ============================================================================
// gshare_fetch_unit_core_test: self-checking bench for the gshare fetch unit
// Drives load and fetch-step beats into the stream input, keeps a cycle-free
// model of the fetch loop (PC, global history, counter table, ROM and the two
// fetch latches), and checks every output beat field by field against it.
// ============================================================================
module gshare_fetch_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROM_DEPTH   = 32768;
  // Longest quiet stretch in a correct run is the table sweep after reset;
  // the watchdog allows several times that.
  localparam int IDLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES = 300;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [gfu_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                     s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [gfu_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_we = 1'b0;
  logic [gfu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gfu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  gshare_fetch_unit_core #(
    .ROM_DEPTH(ROM_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Fetch loop model. It is advanced in the order beats are accepted, so its
  // PC is always the address the next fetch step will read.
  // --------------------------------------------------------------------------
  logic [gfu_pkg::CFG_DATA_W-1:0] mdl_branch_mask;
  logic [gfu_pkg::OP_W-1:0]       mdl_jump_op;
  logic [gfu_pkg::PC_W-1:0]       mdl_pc;
  logic [gfu_pkg::HIST_W-1:0]     mdl_hist;
  logic [gfu_pkg::CNT_W-1:0]      mdl_pht [gfu_pkg::PHT_DEPTH];
  logic [gfu_pkg::INSTR_W-1:0]    mdl_rom [ROM_DEPTH];
  bit                             rom_loaded [ROM_DEPTH];
  gfu_pkg::first_latch_t          mdl_first;
  gfu_pkg::second_latch_t         mdl_second;

  // Second-latch contents still owed by the block, oldest first.
  gfu_pkg::second_latch_t expected_beats [$];

  int errors = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int hold_seq = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic model_reset();
    mdl_branch_mask = '0;
    mdl_jump_op = '0;
    mdl_pc = gfu_pkg::PC_RESET;
    mdl_hist = '0;
    mdl_first = '0;
    mdl_second = '0;
    for (int i = 0; i < gfu_pkg::PHT_DEPTH; i++) mdl_pht[i] = gfu_pkg::CNT_WEAK_NT;
    for (int i = 0; i < ROM_DEPTH; i++) rom_loaded[i] = 1'b0;
  endtask

  // Applies one accepted beat to the model. A fetch step queues the second
  // latch it leaves behind; a load only writes the ROM.
  task automatic model_accept(input logic kind,
                              input logic [gfu_pkg::IN_DATA_W-1:0] data);
    logic [gfu_pkg::LOAD_ADDR_W-1:0] addr;
    logic [gfu_pkg::INSTR_W-1:0]     word;
    logic                            halt;
    logic                            commit;
    logic [gfu_pkg::INSTR_W-1:0]     cdata;
    logic [gfu_pkg::HIST_W-1:0]      cidx;
    logic [gfu_pkg::INSTR_W-1:0]     code;
    logic [gfu_pkg::OP_W-1:0]        op;
    logic                            miss;
    logic [gfu_pkg::HIST_W-1:0]      idx;
    logic [gfu_pkg::CNT_W-1:0]       cnt;
    addr   = data[14:0];
    word   = data[46:15];
    halt   = data[47];
    commit = data[48];
    cdata  = data[80:49];
    cidx   = data[96:81];
    if (kind == gfu_pkg::KIND_LOAD) begin
      mdl_rom[addr % ROM_DEPTH] = word;
      rom_loaded[addr % ROM_DEPTH] = 1'b1;
    end else begin
      code = mdl_rom[mdl_pc % ROM_DEPTH];
      op = code[31:26];
      miss = 1'b0;
      // The commit goes first: history shifts on every commit, and the
      // counter moves only when the prediction was wrong.
      if (commit) begin
        mdl_hist = {mdl_hist[gfu_pkg::HIST_W-2:0], cdata[30]};
        miss = cdata[30] ^ cdata[31];
        if (miss) begin
          cnt = mdl_pht[cidx];
          if (cdata[30]) begin
            if (cnt != gfu_pkg::CNT_MAX) cnt = cnt + 1'b1;
          end else if (cnt != gfu_pkg::CNT_MIN) begin
            cnt = cnt - 1'b1;
          end
          mdl_pht[cidx] = cnt;
        end
      end
      mdl_second.miss = 1'b0;
      if (miss) begin
        // Flush clears only PC and instruction; prediction fields stay.
        mdl_second.miss = 1'b1;
        mdl_pc = cdata[gfu_pkg::PC_W-1:0];
        mdl_first.pc = '0;
        mdl_first.instr = '0;
        mdl_second.pc = '0;
        mdl_second.instr = '0;
      end else if (!halt) begin
        mdl_second = {1'b0, mdl_first};
        mdl_first.pc = mdl_pc;
        mdl_first.instr = code;
        if (op == mdl_jump_op) begin
          // A jump keeps the stale prediction word and index.
          mdl_pc = gfu_pkg::PC_W'(code[gfu_pkg::JUMP_TGT_W-1:0]);
        end else if (mdl_branch_mask[op]) begin
          idx = mdl_pc[gfu_pkg::HIST_W-1:0] ^ mdl_hist;
          mdl_first.index = idx;
          if (mdl_pht[idx] >= gfu_pkg::CNT_WEAK_T) begin
            mdl_first.pred = {1'b1, 9'b0, mdl_pc + 22'd1};
            mdl_pc = gfu_pkg::PC_W'(code[gfu_pkg::BR_TGT_W-1:0]);
          end else begin
            mdl_first.pred = gfu_pkg::INSTR_W'(code[gfu_pkg::BR_TGT_W-1:0]);
            mdl_pc = mdl_pc + 22'd1;
          end
        end else begin
          mdl_first.pred = '0;
          mdl_pc = mdl_pc + 22'd1;
        end
      end
      expected_beats.push_back(mdl_second);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [gfu_pkg::IN_DATA_W-1:0] pack_in(
      input logic [gfu_pkg::LOAD_ADDR_W-1:0] addr,
      input logic [gfu_pkg::INSTR_W-1:0]     word,
      input logic                            halt,
      input logic                            commit,
      input logic [gfu_pkg::INSTR_W-1:0]     cdata,
      input logic [gfu_pkg::HIST_W-1:0]      cidx);
    return {7'b0, cidx, cdata, commit, halt, word, addr};
  endfunction

  // Instruction words for the fetch path: a good share of jumps and branches
  // under the current opcode settings, with targets mostly in a small loop
  // region so the same code and counters are revisited. Some targets sit at
  // the top of the ROM or past it, so that wrapping is exercised.
  function automatic logic [gfu_pkg::INSTR_W-1:0] program_word();
    logic [gfu_pkg::OP_W-1:0]       op;
    logic [gfu_pkg::JUMP_TGT_W-1:0] tgt;
    int                             r;
    r = $urandom_range(99);
    op = gfu_pkg::OP_W'($urandom);
    if (r < 20) begin
      op = mdl_jump_op;
    end else if (r < 55 && mdl_branch_mask != '0) begin
      for (int i = 0; i < 16 && !mdl_branch_mask[op]; i++) op = gfu_pkg::OP_W'($urandom);
    end
    r = $urandom_range(99);
    if (r < 60) tgt = gfu_pkg::JUMP_TGT_W'($urandom_range(0, 95));
    else if (r < 75) tgt = gfu_pkg::JUMP_TGT_W'($urandom_range(32760, 32767));
    else if (r < 85) tgt = gfu_pkg::JUMP_TGT_W'(32768 + $urandom_range(0, 95));
    else tgt = gfu_pkg::JUMP_TGT_W'($urandom);
    return {op, 8'($urandom), tgt};
  endfunction

  function automatic logic [gfu_pkg::PC_W-1:0] redirect_pc();
    int r;
    r = $urandom_range(99);
    if (r < 70) return gfu_pkg::PC_W'($urandom_range(0, 95));
    if (r < 80) return gfu_pkg::PC_W'($urandom_range(32760, 32767));
    if (r < 90) return {7'($urandom), 15'($urandom_range(0, 95))};
    return gfu_pkg::PC_W'($urandom);
  endfunction

  // Offers one beat and returns at the edge it is taken. tvalid is left high
  // so that back-to-back beats stream without a bubble; anything that waits
  // instead of sending lowers it first.
  task automatic send_beat(input logic kind, input logic [gfu_pkg::IN_DATA_W-1:0] data);
    if (src_gaps) begin
      while ($urandom_range(99) < 15) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    model_accept(kind, data);
  endtask

  task automatic load_rom(input logic [gfu_pkg::LOAD_ADDR_W-1:0] addr,
                          input logic [gfu_pkg::INSTR_W-1:0] word);
    send_beat(gfu_pkg::KIND_LOAD, pack_in(addr, word, 1'b0, 1'b0, '0, '0));
  endtask

  // A fetch step never reads a ROM word that was never written: if the word
  // at the current PC is missing, a program word is loaded there first.
  task automatic fetch_step(input logic halt, input logic commit,
                            input logic [gfu_pkg::INSTR_W-1:0] cdata,
                            input logic [gfu_pkg::HIST_W-1:0] cidx);
    if (!rom_loaded[mdl_pc % ROM_DEPTH])
      load_rom(gfu_pkg::LOAD_ADDR_W'(mdl_pc % ROM_DEPTH), program_word());
    send_beat(gfu_pkg::KIND_FETCH,
              pack_in(gfu_pkg::LOAD_ADDR_W'($urandom), $urandom, halt, commit, cdata, cidx));
  endtask

  // Commit indexes mostly point at the latest prediction so that training
  // feeds back into later predictions; the rest are random.
  task automatic random_fetch();
    logic [gfu_pkg::HIST_W-1:0] cidx;
    cidx = ($urandom_range(99) < 60) ? mdl_first.index : gfu_pkg::HIST_W'($urandom);
    fetch_step($urandom_range(99) < 10, $urandom_range(99) < 30,
               {2'($urandom), 8'($urandom), redirect_pc()}, cidx);
  endtask

  // Waits until every owed beat has come, then goes on waiting so that a
  // trailing load has retired before anything else happens.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [gfu_pkg::CFG_DATA_W-1:0] mask,
                            input logic [gfu_pkg::OP_W-1:0] jop);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= gfu_pkg::CFG_BRANCH_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    mdl_branch_mask = mask;
    cfg_index <= gfu_pkg::CFG_JUMP_OP;
    cfg_data  <= gfu_pkg::CFG_DATA_W'(jop);
    @(posedge clk);
    mdl_jump_op = jop;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked sequence: extreme words and addresses, jump and branch on
  // the same opcode, halts, a commit that agrees with its prediction, a
  // redirect to the top of the 22-bit PC space, and counter saturation in
  // both directions.
  task automatic test_directed();
    set_config('1, 6'd63);
    load_rom(15'd0, 32'h0000_0000);
    load_rom(15'h7fff, 32'hffff_ffff);
    // Opcode 63 is both the jump and a branch here; the jump must win. Its
    // 18-bit target wraps onto the last ROM word.
    load_rom(15'd3, {6'd63, 8'hff, 18'h3ffff});
    fetch_step(1'b0, 1'b0, '0, '0);
    fetch_step(1'b0, 1'b0, '0, '0);
    fetch_step(1'b1, 1'b0, '0, '0);
    fetch_step(1'b1, 1'b1, 32'hc000_0000, 16'h0000);
    // Turn the last word into a branch, then redirect to PC 0x3fffff so that
    // its fall-through wraps the PC to zero.
    load_rom(15'h7fff, {6'd5, 26'h0});
    fetch_step(1'b0, 1'b1, {2'b01, 8'hff, 22'h3fffff}, 16'hffff);
    fetch_step(1'b0, 1'b0, '0, '0);
    fetch_step(1'b0, 1'b0, '0, '0);
    fetch_step(1'b0, 1'b0, '0, '0);
    // Drive one counter up past its top and back down past its bottom, on
    // halted steps so that the mispredict overrides the halt.
    repeat (4) fetch_step(1'b1, 1'b1, {2'b01, 8'h00, 22'd40}, 16'h1234);
    repeat (5) fetch_step(1'b1, 1'b1, {2'b10, 8'h00, 22'd40}, 16'h1234);
    repeat (3) fetch_step(1'b0, 1'b0, '0, '0);
  endtask

  // Mostly fetch steps; the rest are loads, some of pure noise and some that
  // rewrite the loop region with fresh program words.
  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8)
        send_beat(gfu_pkg::KIND_LOAD,
                  pack_in(gfu_pkg::LOAD_ADDR_W'($urandom), $urandom, 1'($urandom),
                          1'($urandom), $urandom, gfu_pkg::HIST_W'($urandom)));
      else if (r < 12)
        load_rom(gfu_pkg::LOAD_ADDR_W'($urandom_range(0, 95)), program_word());
      else
        random_fetch();
    end
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the block fills and must stall its input; then the sender waits for
  // every owed beat before going on.
  task automatic test_fill_and_stall();
    src_gaps = 1'b0;
    hold_seq++;
    repeat (40) random_fetch();
    src_gaps = 1'b1;
    drain();
  endtask

  // Full rate on both sides, no idle cycles at all.
  task automatic test_full_rate(input int n);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    test_random(n);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    model_reset();
    test_directed();
    set_config({$urandom, $urandom}, gfu_pkg::OP_W'($urandom));
    test_random(350);
    test_fill_and_stall();
    set_config('0, 6'd0);
    test_random(300);
    set_config({$urandom, $urandom}, 6'd0);
    test_full_rate(300);
    set_config('1, gfu_pkg::OP_W'($urandom));
    test_random(350);
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("gshare_fetch_unit_core_test passed");
    end else begin
      $display("gshare_fetch_unit_core_test failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random idle cycles, plus a long hold-off each time a test bumps
  // hold_seq. The hold-off is counted here, not in the test.
  // --------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !sink_gaps || ($urandom_range(99) >= 15);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every output beat must match the oldest owed second latch.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    gfu_pkg::second_latch_t got;
    gfu_pkg::second_latch_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(gfu_pkg::second_latch_t)-1:0];
      if (expected_beats.size() == 0) begin
        report($sformatf("output beat with no fetch step owed, tdata %h", m_axis_tdata));
      end else begin
        want = expected_beats.pop_front();
        if (got.pc !== want.pc)
          report($sformatf("out_pc got %h expected %h", got.pc, want.pc));
        if (got.instr !== want.instr)
          report($sformatf("out_instr got %h expected %h", got.instr, want.instr));
        if (got.pred !== want.pred)
          report($sformatf("out_pred_word got %h expected %h", got.pred, want.pred));
        if (got.index !== want.index)
          report($sformatf("out_pred_index got %h expected %h", got.index, want.index));
        if (got.miss !== want.miss)
          report($sformatf("out_mispredict got %b expected %b", got.miss, want.miss));
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("gshare_fetch_unit_core_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[sim.f]
rtl/core/gfu_pkg.sv
rtl/core/gfu_rom.sv
rtl/core/gfu_pht.sv
rtl/core/gshare_fetch_unit_core.sv
rtl/core/gfu_checker.sv
bench/gshare_fetch_unit_core_test.sv
